[hw/rtl/mlp_pkg.sv]
// Package with shared constants and types for the MLP inference block.
`default_nettype none
package mlp_pkg;
    localparam int MAX_LAYERS_DEF   = 3;
    localparam int MAX_WIDTH_DEF    = 1024;
    localparam int WEIGHT_WORDS_DEF = 131072;

    localparam logic [1:0] CMD_WEIGHT = 2'd0;
    localparam logic [1:0] CMD_BIAS   = 2'd1;
    localparam logic [1:0] CMD_INPUT  = 2'd2;

    localparam logic [2:0] REG_LAYERS = 3'd0;
    localparam logic [2:0] REG_WIN    = 3'd1;
    localparam logic [2:0] REG_W1     = 3'd2;
    localparam logic [2:0] REG_W2     = 3'd3;
    localparam logic [2:0] REG_W3     = 3'd4;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ROW,
        S_MAC,
        S_DRAIN,
        S_FIN,
        S_DONE
    } t_state;

    // Control from the sequencer to the multiply-accumulate datapath.
    typedef struct packed {
        logic clear;    // load bias into accumulator
        logic mac;      // accumulate the registered product
    } t_mac_ctl;
endpackage
`default_nettype wire

[hw/rtl/mlp_mac.sv]
// Shared multiply-accumulate unit with a registered product stage.
`default_nettype none
module mlp_mac (
    input  wire logic             i_clk,
    input  wire mlp_pkg::t_mac_ctl i_ctl,
    input  wire logic             i_prod_en,
    input  wire logic signed [15:0] i_bias,
    input  wire logic signed [15:0] i_weight,
    input  wire logic signed [15:0] i_act,
    output logic signed [63:0]    o_acc
);
    import mlp_pkg::*;
    logic signed [31:0] r_prod;
    logic signed [63:0] r_acc;

    always_ff @(posedge i_clk) begin
        if (i_prod_en) begin
            r_prod <= i_weight * i_act;
        end
        if (i_ctl.clear) begin
            r_acc <= 64'(i_bias) <<< 8;
        end else if (i_ctl.mac) begin
            r_acc <= r_acc + 64'(r_prod);
        end
    end
    assign o_acc = r_acc;
endmodule
`default_nettype wire

[hw/rtl/mlp_relu_inference_argmax_top.sv]
// Top level of the fixed-point MLP inference block with argmax output.
`default_nettype none
// Usage: each transaction on the command channel (start while busy is low)
// carries i_cmd, i_position, i_value and i_last. Weight writes (cmd 0), bias
// writes (cmd 1) and input elements (cmd 2) go straight into memory, so loads
// can stream one per cycle while busy is low. An input element with i_last set
// starts the forward pass; busy stays high until the result is out.
// One shared 16x16 multiplier with a registered product and a 64-bit
// accumulator does one multiply-accumulate per cycle, and the weight, bias
// and activation memories each give one registered read per cycle. Each
// output row runs through a bias read, the issue of one product per input, a
// drain of the read and product pipeline, and a store or compare of the row.
// busy stays high through every row of every layer and while o_done is high,
// after which the next transaction is taken. o_done is high for exactly one
// cycle with the result on o_class_index and o_best_logit; the receiver
// cannot stall, so nothing is held back.
// Configuration writes through i_cfg_we/i_cfg_index/i_cfg_data take effect
// at once and are only allowed while the block is idle.
// Reset is synchronous and active low; it restores the register defaults
// and idles the sequencer. The memories are not cleared; reading an entry
// that was never written gives undefined data.
module mlp_relu_inference_argmax_top #(
    parameter int MAX_LAYERS   = mlp_pkg::MAX_LAYERS_DEF,
    parameter int MAX_WIDTH    = mlp_pkg::MAX_WIDTH_DEF,
    parameter int WEIGHT_WORDS = mlp_pkg::WEIGHT_WORDS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  i_cmd,
    input  wire logic [16:0] i_position,
    input  wire logic signed [15:0] i_value,
    input  wire logic        i_last,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [10:0] i_cfg_data,
    output logic             o_done,
    output logic [9:0]       o_class_index,
    output logic signed [31:0] o_best_logit
);
    import mlp_pkg::*;

    localparam int AW  = $clog2(MAX_WIDTH);
    localparam int WAW = $clog2(WEIGHT_WORDS);
    localparam int BD  = MAX_LAYERS * MAX_WIDTH;
    localparam int BAW = $clog2(BD);
    localparam int NL  = (MAX_LAYERS < 3) ? MAX_LAYERS : 3;

    // Configuration registers.
    logic [1:0]  r_layers;
    logic [10:0] r_win, r_w1, r_w2, r_w3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_layers <= 2'd2;
            r_win    <= 11'd784;
            r_w1     <= 11'd128;
            r_w2     <= 11'd10;
            r_w3     <= 11'd10;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_LAYERS: r_layers <= i_cfg_data[1:0];
                REG_WIN:    r_win    <= i_cfg_data;
                REG_W1:     r_w1     <= i_cfg_data;
                REG_W2:     r_w2     <= i_cfg_data;
                REG_W3:     r_w3     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Widths clamped to 1..MAX_WIDTH, held as count (AW+1 bits).
    function automatic logic [AW:0] clamp_w(input logic [10:0] w);
        logic [AW:0] m;
        m = (AW+1)'(MAX_WIDTH);
        if (w == 11'd0) return (AW+1)'(1);
        if (32'(w) > MAX_WIDTH) return m;
        return (AW+1)'(w);
    endfunction

    logic [1:0] n_layers_eff;
    always_comb begin
        if (r_layers == 2'd0) n_layers_eff = 2'd1;
        else if (32'(r_layers) > NL) n_layers_eff = 2'(NL);
        else n_layers_eff = r_layers;
    end

    // Sequencer state.
    t_state r_state, n_state;
    logic [1:0]   r_layer;
    logic [AW:0]  r_in, r_out;
    logic [AW:0]  r_row, r_col;
    logic [WAW-1:0] r_waddr;
    logic [BAW:0] r_boff;
    logic         r_src;       // 0: ping is source
    logic         r_final;
    logic         r_pv;        // product register holds valid data
    logic [1:0]   r_drain;
    logic signed [31:0] r_best;
    logic [9:0]   r_bpos;

    logic accept;
    assign accept = start && !busy;
    assign busy   = (r_state != S_IDLE);

    // Memories.
    logic signed [15:0] wmem [WEIGHT_WORDS];
    logic signed [15:0] bmem [BD];
    logic signed [15:0] ping [MAX_WIDTH];
    logic signed [15:0] pong [MAX_WIDTH];
    logic signed [15:0] r_wrd, r_brd, r_prd, r_qrd;

    logic wr_res;
    logic signed [15:0] res_q;
    logic [AW-1:0] res_addr;

    always_ff @(posedge i_clk) begin
        if (accept && i_cmd == CMD_WEIGHT) wmem[i_position[WAW-1:0]] <= i_value;
        r_wrd <= wmem[r_waddr];
    end

    logic [BAW:0] baddr;
    assign baddr = r_boff + (BAW+1)'(r_row);
    always_ff @(posedge i_clk) begin
        if (accept && i_cmd == CMD_BIAS && 32'(i_position) < BD)
            bmem[i_position[BAW-1:0]] <= i_value;
        r_brd <= bmem[baddr[BAW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (accept && i_cmd == CMD_INPUT && 32'(i_position) < MAX_WIDTH)
            ping[i_position[AW-1:0]] <= i_value;
        else if (wr_res && r_src)
            ping[res_addr] <= res_q;
        r_prd <= ping[r_col[AW-1:0]];
    end
    always_ff @(posedge i_clk) begin
        if (wr_res && !r_src) pong[res_addr] <= res_q;
        r_qrd <= pong[r_col[AW-1:0]];
    end

    // Shared MAC unit.
    t_mac_ctl mctl;
    logic signed [63:0] acc;
    logic r_rd;     // memory read issued last cycle
    mlp_mac u_mac (
        .i_clk(i_clk), .i_ctl(mctl), .i_prod_en(r_rd),
        .i_bias(r_brd), .i_weight(r_wrd), .i_act(r_src ? r_qrd : r_prd),
        .o_acc(acc)
    );

    // Apply ReLU, requantize and saturate the finished row.
    logic signed [31:0] sat;
    logic [63:0] q;
    always_comb begin
        q = 64'd0;
        if (acc > 64'sd0) q = (64'(acc) + 64'd2048) >> 12;
        res_q = (q > 64'd32767) ? 16'sd32767 : 16'(q);
        if (acc > 64'sd2147483647) sat = 32'sh7fffffff;
        else if (acc < -64'sd2147483648) sat = 32'sh80000000;
        else sat = 32'(acc);
    end
    assign res_addr = r_row[AW-1:0];

    function automatic logic [AW:0] width_of(input logic [1:0] k);
        unique case (k)
            2'd0: return clamp_w(r_win);
            2'd1: return clamp_w(r_w1);
            2'd2: return clamp_w(r_w2);
            default: return clamp_w(r_w3);
        endcase
    endfunction

    logic start_pass, mac_issue, row_end;
    assign start_pass = accept && i_cmd == CMD_INPUT && i_last;
    assign row_end    = (r_row + (AW+1)'(1) == r_out);

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (start_pass) n_state = S_ROW;
            S_ROW:   n_state = S_MAC;
            S_MAC:   if (r_col + (AW+1)'(1) == r_in) n_state = S_DRAIN;
            S_DRAIN: if (r_drain == 2'd2) n_state = S_FIN;
            S_FIN: begin
                if (row_end && r_final) n_state = S_DONE;
                else n_state = S_ROW;
            end
            S_DONE:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Output / control decode.
    always_comb begin
        mctl.mac   = r_pv;
        mac_issue  = (r_state == S_MAC);
        wr_res     = (r_state == S_FIN) && !r_final;
        o_done     = (r_state == S_DONE);
        // Bias is read in S_ROW, loaded into the accumulator next cycle.
        mctl.clear = (r_state == S_MAC) && (r_col == '0) && !r_pv;
    end
    assign o_class_index = r_bpos;
    assign o_best_logit  = r_best;

    // Sequencer registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_rd    <= 1'b0;
            r_pv    <= 1'b0;
            r_best  <= '0;
            r_bpos  <= '0;
        end else begin
            r_state <= n_state;
            r_rd    <= mac_issue;
            r_pv    <= r_rd;
            unique case (r_state)
                S_IDLE: if (start_pass) begin
                    r_layer <= 2'd0;
                    r_in    <= width_of(2'd0);
                    r_out   <= width_of(2'd1);
                    r_final <= (n_layers_eff == 2'd1);
                    r_row   <= '0;
                    r_col   <= '0;
                    r_waddr <= '0;
                    r_boff  <= '0;
                    r_src   <= 1'b0;
                end
                S_ROW: begin
                    r_col   <= '0;
                    r_drain <= 2'd0;
                end
                S_MAC: begin
                    r_col   <= r_col + (AW+1)'(1);
                    r_waddr <= r_waddr + WAW'(1);
                end
                S_DRAIN: r_drain <= r_drain + 2'd1;
                S_FIN: begin
                    if (r_final && (r_row == '0 || sat > r_best)) begin
                        r_best <= sat;
                        r_bpos <= 10'(r_row);
                    end
                    r_col <= '0;
                    if (row_end) begin
                        r_row   <= '0;
                        r_boff  <= r_boff + (BAW+1)'(r_out);
                        r_layer <= r_layer + 2'd1;
                        r_in    <= r_out;
                        r_out   <= width_of(r_layer + 2'd2);
                        r_final <= (r_layer + 2'd2 == n_layers_eff);
                        r_src   <= ~r_src;
                    end else begin
                        r_row <= r_row + (AW+1)'(1);
                    end
                end
                S_DONE: ;
                default: ;
            endcase
        end
    end

    // The accumulator clear in the first MAC cycle uses the bias read in S_ROW;
    // products pass through the registered memory reads and r_prod and never collide with the clear.

    // Assertions.
    a_done_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done) else $error("done held two cycles");
    a_busy_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> busy) else $error("done while idle");
    a_pass_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start_pass |=> busy) else $error("pass did not start");
    a_no_res_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_res |-> !o_done) else $error("hidden write with result");
endmodule
`default_nettype wire
